// ----- rtl/differential_drive_odometry_defines.svh -----
// Assertion macros shared by the odometry RTL
`ifndef DIFFERENTIAL_DRIVE_ODOMETRY_DEFINES_SVH
`define DIFFERENTIAL_DRIVE_ODOMETRY_DEFINES_SVH

// same-cycle implication, sampled on clk, off during rst
`define DDO_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define DDO_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/ddo_pkg.sv -----
// Shared widths, constants, tables and types for the odometry block
package ddo_pkg;

  localparam int POS_W     = 32;
  localparam int HEAD_W    = 31;
  localparam int DPT_W     = 24;
  localparam int HPT_W     = 30;
  localparam int LPT_W     = 24;
  localparam int CFG_W     = 30;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DISTANCE = 2'd0,
    CFG_HEADING  = 2'd1,
    CFG_LATERAL  = 2'd2
  } cfg_reg_t;

  localparam logic [DPT_W-1:0] DPT_RESET = 24'd65536;
  localparam logic [HPT_W-1:0] HPT_RESET = 30'd268435456;
  localparam logic [LPT_W-1:0] LPT_RESET = 24'd0;

  localparam logic [HEAD_W-1:0] TWO_PI_Q28  = 31'd1686629713;
  localparam logic [HEAD_W-1:0] PI_Q28      = 31'd843314857;
  localparam logic [HEAD_W-1:0] HALF_PI_Q28 = 31'd421657428;
  localparam logic signed [31:0] CORDIC_GAIN_Q28 = 32'sd163008218;

  localparam int CORDIC_STEPS_DEF = 24;
  localparam int ATAN_N  = 32;
  localparam int ATAN_IW = 5;

  localparam logic [31:0] ATAN_Q28 [ATAN_N] = '{
    32'd210828714, 32'd124459457, 32'd65760959, 32'd33381290,
    32'd16755422,  32'd8385879,   32'd4193963,  32'd2097109,
    32'd1048571,   32'd524287,    32'd262144,   32'd131072,
    32'd65536,     32'd32768,     32'd16384,    32'd8192,
    32'd4096,      32'd2048,      32'd1024,     32'd512,
    32'd256,       32'd128,       32'd64,       32'd32,
    32'd16,        32'd8,         32'd4,        32'd2,
    32'd1,         32'd1,         32'd0,        32'd0
  };

  // serial multipliers: signed operand widths and product width
  localparam int MUL_AW = 35;
  localparam int MUL_BW = 31;
  localparam int MUL_PW = MUL_AW + MUL_BW;
  localparam int MUL_N  = 4;

  localparam int TURN_W = 49;
  localparam int DXY_W  = 39;

  // remainder by two pi: restoring subtract, one quotient bit a cycle
  localparam int REM_W     = 49;
  localparam int REM_STEPS = 19;
  localparam int REM_CW    = 5;
  localparam logic [REM_W-1:0] REM_D0 = REM_W'(TWO_PI_Q28) << (REM_STEPS - 1);

  localparam logic signed [MUL_AW-1:0] INC_MAX = 35'sh2_0000_0000;
  localparam logic signed [MUL_AW-1:0] INC_MIN = -INC_MAX;

  typedef enum logic [3:0] {
    S_IDLE, S_DIFF, S_MUL1, S_MID, S_REM, S_CORDIC, S_ROT, S_MUL2, S_SUM, S_POSE, S_OUT
  } state_t;

endpackage

// ----- rtl/ddo_in_if.sv -----
// Input channel: encoder readings and mode
interface ddo_in_if;
  logic                              valid;
  logic                              ready;
  logic                              mode;
  logic signed [ddo_pkg::POS_W-1:0]  left_position;
  logic signed [ddo_pkg::POS_W-1:0]  right_position;

  modport source (output valid, mode, left_position, right_position, input ready);
  modport sink   (input valid, mode, left_position, right_position, output ready);
endinterface

// ----- rtl/ddo_out_if.sv -----
// Output channel: pose
interface ddo_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [ddo_pkg::POS_W-1:0]  x_position;
  logic signed [ddo_pkg::POS_W-1:0]  y_position;
  logic [ddo_pkg::HEAD_W-1:0]        heading;

  modport source (output valid, x_position, y_position, heading, input ready);
  modport sink   (input valid, x_position, y_position, heading, output ready);
endinterface

// ----- rtl/ddo_serial_mul.sv -----
// Bit-serial signed multiplier, one multiplier bit per cycle
module ddo_serial_mul #(
  parameter int WA = ddo_pkg::MUL_AW,
  parameter int WB = ddo_pkg::MUL_BW
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [WA-1:0]    a,
  input  logic signed [WB-1:0]    b,
  output logic signed [WA+WB-1:0] product,
  output logic                    done
);
  localparam int CW = $clog2(WB + 1);

  logic signed [WA-1:0] a_r;
  logic signed [WA:0]   hi;
  logic [WB-1:0]        lo;
  logic [CW-1:0]        cnt;
  logic signed [WA+1:0] pp;
  logic signed [WA+1:0] sum;
  logic [WA+WB:0]       acc;

  always_comb begin
    pp  = lo[0] ? (WA+2)'(a_r) : '0;
    sum = (cnt == CW'(1)) ? ((WA+2)'(hi) - pp) : ((WA+2)'(hi) + pp);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= CW'(WB);
      end else if (cnt != '0) begin
        cnt  <= cnt - CW'(1);
        done <= (cnt == CW'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
      hi  <= '0;
      lo  <= b;
    end else if (cnt != '0) begin
      hi <= sum[WA+1:1];
      lo <= {sum[0], lo[WB-1:1]};
    end
  end

  assign acc     = {hi, lo};
  assign product = acc[WA+WB-1:0];

endmodule

// ----- rtl/differential_drive_odometry.sv -----
// Differential-drive odometry top level: pose update from encoder readings
// An update steps through DIFF, MUL1, MID, REM, CORDIC, ROT, MUL2, SUM and POSE; a clear
// goes straight to OUT. An update makes two passes of the shared bit-serial multipliers
// and of the two-pi remainder unit, and one of the CORDIC loop. Readings are taken in IDLE only.
// A new transaction is taken while the previous pose still waits at the output.
// Reset (synchronous, rst high): pose (0, 0, pi/2), readings zero, registers
// at their reset values.
`include "differential_drive_odometry_defines.svh"

module differential_drive_odometry #(
  parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [ddo_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ddo_pkg::CFG_W-1:0]       cfg_data,
  ddo_in_if.sink                          in_ch,
  ddo_out_if.source                       out_ch
);
  import ddo_pkg::*;

  localparam int CIW = $clog2(CORDIC_STEPS);

  state_t state, state_next;

  logic [DPT_W-1:0]        distance_per_turn;
  logic [HPT_W-1:0]        heading_per_turn;
  logic signed [LPT_W-1:0] lateral_per_turn;

  logic signed [POS_W-1:0] last_left, last_right, pose_x, pose_y;
  logic [HEAD_W-1:0]       pose_heading;
  logic signed [POS_W:0]   dl, dr;
  logic signed [MUL_AW-1:0] fwd, lat;
  logic signed [TURN_W-1:0] turn;
  logic signed [DXY_W-1:0] dx, dy;

  logic [REM_W-1:0]  rem_r, rem_d;
  logic [REM_CW-1:0] rem_cnt;
  logic              rem_neg, h_hi, h_lo;
  logic [HEAD_W-1:0] h_t;

  logic signed [31:0] cx, cy, cz;
  logic               neg_cos;
  logic [CIW-1:0]     cord_i;

  logic                    out_valid;
  logic signed [POS_W-1:0] out_x, out_y;
  logic [HEAD_W-1:0]       out_h;

  logic                     mul_start;
  logic signed [MUL_AW-1:0] mul_a [MUL_N];
  logic signed [MUL_BW-1:0] mul_b [MUL_N];
  logic signed [MUL_PW-1:0] prod  [MUL_N];
  logic [MUL_N-1:0]         mul_done;

  logic                     in_take, out_load, cord_last;
  logic signed [POS_W+1:0]  ss, sl;
  logic signed [TURN_W-1:0] mid, tsum;
  logic [HEAD_W-1:0]        a0;
  logic signed [31:0]       a1, zf;
  logic                     fold;
  logic signed [31:0]       sx, sy, atan_i, c_fin;
  logic signed [MUL_PW:0]   dx_full, dy_full;
  logic signed [POS_W+7:0]  x_sum, y_sum;
  logic [HEAD_W-1:0]        h_new;

  function automatic logic signed [MUL_AW-1:0] clamp_inc(input logic signed [49:0] v);
    logic signed [MUL_AW-1:0] r;
    if (v > 50'(INC_MAX))      r = INC_MAX;
    else if (v < 50'(INC_MIN)) r = INC_MIN;
    else                       r = v[MUL_AW-1:0];
    return r;
  endfunction

  function automatic logic signed [POS_W-1:0] clamp_pos(input logic signed [POS_W+7:0] v);
    logic signed [POS_W-1:0] r;
    if (v > 40'sd2147483647)       r = 32'sh7FFF_FFFF;
    else if (v < -40'sd2147483648) r = 32'sh8000_0000;
    else                           r = v[POS_W-1:0];
    return r;
  endfunction

  assign in_ch.ready       = (state == S_IDLE);
  assign in_take           = in_ch.valid && in_ch.ready;
  assign out_load          = (state == S_OUT) && (!out_valid || out_ch.ready);
  assign out_ch.valid      = out_valid;
  assign out_ch.x_position = out_x;
  assign out_ch.y_position = out_y;
  assign out_ch.heading    = out_h;

  assign cord_last = (cord_i == CIW'(CORDIC_STEPS - 1));

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    mul_start  = 1'b0;
    case (state)
      S_IDLE:   if (in_take) state_next = in_ch.mode ? S_OUT : S_DIFF;
      S_DIFF: begin
        mul_start  = 1'b1;
        state_next = S_MUL1;
      end
      S_MUL1:   if (mul_done[0]) state_next = S_MID;
      S_MID:    state_next = S_REM;
      S_REM:    if (rem_cnt == '0) state_next = S_CORDIC;
      S_CORDIC: if (cord_last) state_next = S_ROT;
      S_ROT: begin
        mul_start  = 1'b1;
        state_next = S_MUL2;
      end
      S_MUL2:   if (mul_done[0]) state_next = S_SUM;
      S_SUM:    state_next = S_POSE;
      S_POSE:   state_next = S_OUT;
      S_OUT:    if (out_load) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // multiplier operands: increments first, then rotation
  always_comb begin
    ss    = (POS_W+2)'(dr) + (POS_W+2)'(dl);
    sl    = (POS_W+2)'(dr) - (POS_W+2)'(dl);
    c_fin = neg_cos ? -cx : cx;
    if (state == S_DIFF) begin
      mul_a[0] = MUL_AW'(ss);
      mul_b[0] = MUL_BW'({1'b0, distance_per_turn});
      mul_a[1] = MUL_AW'(sl);
      mul_b[1] = -MUL_BW'(lateral_per_turn);
      mul_a[2] = MUL_AW'(sl);
      mul_b[2] = MUL_BW'({1'b0, heading_per_turn});
      mul_a[3] = '0;
      mul_b[3] = '0;
    end else begin
      mul_a[0] = fwd;
      mul_b[0] = c_fin[MUL_BW-1:0];
      mul_a[1] = lat;
      mul_b[1] = cy[MUL_BW-1:0];
      mul_a[2] = fwd;
      mul_b[2] = cy[MUL_BW-1:0];
      mul_a[3] = lat;
      mul_b[3] = c_fin[MUL_BW-1:0];
    end
  end

  for (genvar g = 0; g < MUL_N; g++) begin : g_mul
    ddo_serial_mul #(.WA(MUL_AW), .WB(MUL_BW)) u_mul (
      .clk     (clk),
      .rst     (rst),
      .start   (mul_start),
      .a       (mul_a[g]),
      .b       (mul_b[g]),
      .product (prod[g]),
      .done    (mul_done[g])
    );
  end

  always_comb begin
    mid  = $signed(TURN_W'(pose_heading)) + (turn >>> 1);
    tsum = $signed(TURN_W'(pose_heading)) + turn;
    a0   = rem_neg ? (TWO_PI_Q28 - 31'd1 - rem_r[HEAD_W-1:0]) : rem_r[HEAD_W-1:0];
    a1   = (a0 >= PI_Q28) ? (32'(a0) - 32'(TWO_PI_Q28)) : 32'(a0);
    fold = 1'b0;
    zf   = a1;
    if (a1 > $signed(32'(HALF_PI_Q28))) begin
      zf   = 32'(PI_Q28) - a1;
      fold = 1'b1;
    end else if (a1 < -$signed(32'(HALF_PI_Q28))) begin
      zf   = -32'(PI_Q28) - a1;
      fold = 1'b1;
    end
    sx      = cx >>> cord_i;
    sy      = cy >>> cord_i;
    atan_i  = ATAN_Q28[ATAN_IW'(cord_i)];
    dx_full = (MUL_PW+1)'(prod[0]) - (MUL_PW+1)'(prod[1]);
    dy_full = (MUL_PW+1)'(prod[2]) + (MUL_PW+1)'(prod[3]);
    x_sum   = (POS_W+8)'(pose_x) + (POS_W+8)'(dx);
    y_sum   = (POS_W+8)'(pose_y) + (POS_W+8)'(dy);
    if (h_hi)      h_new = rem_r[HEAD_W-1:0] + 31'd1;
    else if (h_lo) h_new = TWO_PI_Q28 - 31'd1 - rem_r[HEAD_W-1:0];
    else           h_new = h_t;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      distance_per_turn <= DPT_RESET;
      heading_per_turn  <= HPT_RESET;
      lateral_per_turn  <= LPT_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_DISTANCE: distance_per_turn <= cfg_data[DPT_W-1:0];
        CFG_HEADING:  heading_per_turn  <= cfg_data[HPT_W-1:0];
        CFG_LATERAL:  lateral_per_turn  <= cfg_data[LPT_W-1:0];
        default: ;
      endcase
    end
  end

  // pose and readings
  always_ff @(posedge clk) begin
    if (rst) begin
      last_left    <= '0;
      last_right   <= '0;
      pose_x       <= '0;
      pose_y       <= '0;
      pose_heading <= HALF_PI_Q28;
    end else if (in_take) begin
      if (in_ch.mode) begin
        last_left    <= '0;
        last_right   <= '0;
        pose_x       <= '0;
        pose_y       <= '0;
        pose_heading <= HALF_PI_Q28;
      end else begin
        last_left  <= in_ch.left_position;
        last_right <= in_ch.right_position;
      end
    end else if (state == S_POSE) begin
      pose_x       <= clamp_pos(x_sum);
      pose_y       <= clamp_pos(y_sum);
      pose_heading <= h_new;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      dl <= (POS_W+1)'(in_ch.left_position) - (POS_W+1)'(last_left);
      dr <= (POS_W+1)'(in_ch.right_position) - (POS_W+1)'(last_right);
    end
    if (state == S_MUL1 && mul_done[0]) begin
      fwd  <= clamp_inc(50'($signed(prod[0][MUL_PW-1:17])));
      lat  <= clamp_inc(prod[1][MUL_PW-1:16]);
      turn <= prod[2][TURN_W+15:16];
    end
    if (state == S_MUL2 && mul_done[0]) begin
      dx <= dx_full[MUL_PW:28];
      dy <= dy_full[MUL_PW:28];
    end
  end

  // remainder unit, shared by the midpoint angle and the heading wrap
  always_ff @(posedge clk) begin
    if (rst) begin
      rem_cnt <= '0;
    end else if (state == S_MID || (state == S_REM && rem_cnt == '0)) begin
      rem_cnt <= REM_CW'(REM_STEPS);
    end else if (rem_cnt != '0) begin
      rem_cnt <= rem_cnt - REM_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_MID) begin
      rem_neg <= mid[TURN_W-1];
      rem_r   <= mid[TURN_W-1] ? REM_W'(~mid) : REM_W'(mid);
      rem_d   <= REM_D0;
    end else if (state == S_REM && rem_cnt == '0) begin
      h_hi  <= (tsum > $signed(TURN_W'(TWO_PI_Q28)));
      h_lo  <= tsum[TURN_W-1];
      h_t   <= tsum[HEAD_W-1:0];
      rem_r <= tsum[TURN_W-1] ? REM_W'(~tsum) : REM_W'(tsum - TURN_W'(1));
      rem_d <= REM_D0;
    end else if (rem_cnt != '0) begin
      if (rem_r >= rem_d) rem_r <= rem_r - rem_d;
      rem_d <= rem_d >> 1;
    end
  end

  // CORDIC rotation mode
  always_ff @(posedge clk) begin
    if (state == S_REM && rem_cnt == '0) begin
      cx      <= CORDIC_GAIN_Q28;
      cy      <= '0;
      cz      <= zf;
      neg_cos <= fold;
      cord_i  <= '0;
    end else if (state == S_CORDIC) begin
      if (!cz[31]) begin
        cx <= cx - sy;
        cy <= cy + sx;
        cz <= cz - atan_i;
      end else begin
        cx <= cx + sy;
        cy <= cy - sx;
        cz <= cz + atan_i;
      end
      cord_i <= cord_i + CIW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_x <= pose_x;
      out_y <= pose_y;
      out_h <= pose_heading;
    end
  end

  `DDO_ASSERT_NOW(a_heading_range, 1'b1, pose_heading <= TWO_PI_Q28, "heading out of range")
  `DDO_ASSERT_NOW(a_wrap_ready, state == S_POSE, rem_cnt == '0, "heading wrap not finished")
  `DDO_ASSERT_NEXT(a_hold_result, state == S_OUT && out_valid && !out_ch.ready, state == S_OUT, "pending pose overwritten")
  `DDO_ASSERT_NEXT(a_clear_pose, in_take && in_ch.mode, pose_heading == HALF_PI_Q28 && pose_x == '0, "clear transaction did not reset pose")

endmodule

// ----- tb/differential_drive_odometry_tb.sv -----
// Self-checking testbench for the differential-drive odometry block
module differential_drive_odometry_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ddo_pkg::*;

  typedef logic signed [95:0] wide_t;
  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic [30:0]        h;
  } pose_t;
  typedef struct {
    logic               mode;
    logic signed [31:0] left;
    logic signed [31:0] right;
    bit                 typed;
    pose_t              pose;
  } stim_row_t;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam logic MODE_UPDATE = 1'b0;
  localparam logic MODE_CLEAR  = 1'b1;
  localparam int   STEPS       = CORDIC_STEPS_DEF;
  localparam pose_t HOME = '{x: 32'sd0, y: 32'sd0, h: HALF_PI_Q28};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_DISTANCE;
  logic [CFG_W-1:0] cfg_data = '0;
  bit idling = 1'b1;
  int errors = 0;

  ddo_in_if  in_ch ();
  ddo_out_if out_ch ();

  differential_drive_odometry dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_ch(in_ch), .out_ch(out_ch)
  );

  always #1 clk = ~clk;

  // tracked pose, readings and coefficients
  logic signed [31:0] trk_left, trk_right, trk_x, trk_y;
  logic [30:0] trk_heading;
  logic [23:0] dist_coef;
  logic [29:0] head_coef;
  logic signed [23:0] lat_coef;
  pose_t pending_poses[$];

  function automatic wide_t floor_mod(wide_t v, wide_t m);
    wide_t r;
    r = v % m;
    return (r < 0) ? r + m : r;
  endfunction

  function automatic wide_t clip(wide_t v, wide_t lo, wide_t hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic void cordic_sincos(input wide_t angle, output wide_t c, output wide_t s);
    wide_t a, cx, cy, xs, ys, z, twopi, pi, hpi;
    bit flip;
    twopi = wide_t'(TWO_PI_Q28);
    pi = wide_t'(PI_Q28);
    hpi = wide_t'(HALF_PI_Q28);
    a = floor_mod(angle, twopi);
    flip = 1'b0;
    if (a >= pi) a = a - twopi;
    if (a > hpi) begin
      a = pi - a;
      flip = 1'b1;
    end else if (a < -hpi) begin
      a = -pi - a;
      flip = 1'b1;
    end
    cx = wide_t'(CORDIC_GAIN_Q28);
    cy = 0;
    z = a;
    for (int i = 0; i < STEPS && i < ATAN_N; i++) begin
      xs = cx >>> i;
      ys = cy >>> i;
      if (z >= 0) begin
        cx = cx - ys; cy = cy + xs; z = z - wide_t'(ATAN_Q28[i]);
      end else begin
        cx = cx + ys; cy = cy - xs; z = z + wide_t'(ATAN_Q28[i]);
      end
    end
    c = flip ? -cx : cx;
    s = cy;
  endfunction

  function automatic pose_t advance_pose(logic mode, logic signed [31:0] l,
                                         logic signed [31:0] r);
    wide_t dl, dr, ss, sl, fwd, lat, turn, c, s, t, lim, twopi;
    pose_t p;
    twopi = wide_t'(TWO_PI_Q28);
    lim = wide_t'(64'sd8589934592);
    if (mode == MODE_CLEAR) begin
      trk_left = '0; trk_right = '0; trk_x = '0; trk_y = '0;
      trk_heading = HALF_PI_Q28;
    end else begin
      dl = wide_t'(l) - wide_t'(trk_left);
      dr = wide_t'(r) - wide_t'(trk_right);
      ss = dr + dl;
      sl = dr - dl;
      fwd = (ss * wide_t'(dist_coef)) >>> 17;
      lat = (-(sl * wide_t'(lat_coef))) >>> 16;
      turn = (sl * wide_t'(head_coef)) >>> 16;
      trk_left = l;
      trk_right = r;
      cordic_sincos(wide_t'(trk_heading) + (turn >>> 1), c, s);
      fwd = clip(fwd, -lim, lim);
      lat = clip(lat, -lim, lim);
      trk_x = 32'(clip(wide_t'(trk_x) + ((fwd * c - lat * s) >>> 28),
                       -wide_t'(64'sd2147483648), wide_t'(64'sd2147483647)));
      trk_y = 32'(clip(wide_t'(trk_y) + ((fwd * s + lat * c) >>> 28),
                       -wide_t'(64'sd2147483648), wide_t'(64'sd2147483647)));
      t = wide_t'(trk_heading) + turn;
      if (t > twopi) t = floor_mod(t - 1, twopi) + 1;
      else if (t < 0) t = floor_mod(t, twopi);
      trk_heading = 31'(t);
    end
    p.x = trk_x; p.y = trk_y; p.h = trk_heading;
    return p;
  endfunction

  task automatic write_coefs(logic [23:0] d, logic [29:0] h, logic signed [23:0] la);
    cfg_we <= 1'b1; cfg_index <= CFG_DISTANCE; cfg_data <= CFG_W'(d);
    @(negedge clk);
    cfg_index <= CFG_HEADING; cfg_data <= h;
    @(negedge clk);
    cfg_index <= CFG_LATERAL; cfg_data <= CFG_W'({6'h2a, la});
    @(negedge clk);
    cfg_index <= CFG_UNUSED; cfg_data <= CFG_W'($urandom);
    @(negedge clk);
    cfg_we <= 1'b0;
    dist_coef = d; head_coef = h; lat_coef = la;
  endtask

  task automatic send_item(stim_row_t row);
    pose_t p;
    if (idling && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.mode <= row.mode;
    in_ch.left_position <= row.left;
    in_ch.right_position <= row.right;
    do @(posedge clk); while (!in_ch.ready);
    p = advance_pose(row.mode, row.left, row.right);
    pending_poses.push_back(row.typed ? row.pose : p);
    @(negedge clk);
  endtask

  task automatic drain;
    while (pending_poses.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  initial begin
    out_ch.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (idling && $urandom_range(0, 2) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(negedge clk);
    end
  end

  always @(posedge clk) begin
    pose_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_poses.size() == 0) begin
        $error("pose transaction with nothing expected");
        errors++;
      end else begin
        want = pending_poses.pop_front();
        if (out_ch.x_position !== want.x) begin
          $error("x_position: expected %0d, got %0d", want.x, out_ch.x_position);
          errors++;
        end
        if (out_ch.y_position !== want.y) begin
          $error("y_position: expected %0d, got %0d", want.y, out_ch.y_position);
          errors++;
        end
        if (out_ch.heading !== want.h) begin
          $error("heading: expected %0d, got %0d", want.h, out_ch.heading);
          errors++;
        end
      end
    end
  end

  initial begin
    #10000000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    stim_row_t rows[$];
    stim_row_t row;
    logic [23:0] d;
    logic [29:0] h;
    logic signed [23:0] la;
    int sel, span;
    in_ch.valid = 1'b0;
    in_ch.mode = MODE_UPDATE;
    in_ch.left_position = '0;
    in_ch.right_position = '0;
    trk_left = '0; trk_right = '0; trk_x = '0; trk_y = '0;
    trk_heading = HALF_PI_Q28;
    dist_coef = DPT_RESET; head_coef = HPT_RESET; lat_coef = LPT_RESET;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    rows.push_back('{MODE_CLEAR, 32'sd5, -32'sd5, 1'b1, HOME});
    rows.push_back('{MODE_UPDATE, 32'sd0, 32'sd0, 1'b1, HOME});
    rows.push_back('{MODE_UPDATE, 32'sd65536, 32'sd65536, 1'b0, HOME});
    rows.push_back('{MODE_UPDATE, 32'sd65536, 32'sd196608, 1'b0, HOME});
    rows.push_back('{MODE_UPDATE, 32'h7fffffff, 32'h7fffffff, 1'b0, HOME});
    rows.push_back('{MODE_UPDATE, 32'h80000000, 32'h7fffffff, 1'b0, HOME});
    rows.push_back('{MODE_UPDATE, 32'h7fffffff, 32'h80000000, 1'b0, HOME});
    rows.push_back('{MODE_UPDATE, 32'h80000000, 32'h80000000, 1'b0, HOME});
    rows.push_back('{MODE_CLEAR, 32'h7fffffff, 32'h80000000, 1'b1, HOME});
    rows.push_back('{MODE_UPDATE, -32'sd1, 32'sd0, 1'b0, HOME});
    rows.push_back('{MODE_UPDATE, 32'sd0, -32'sd1, 1'b0, HOME});
    rows.push_back('{MODE_UPDATE, 32'h55555555, 32'haaaaaaaa, 1'b0, HOME});
    rows.push_back('{MODE_UPDATE, 32'haaaaaaaa, 32'h55555555, 1'b0, HOME});
    rows.push_back('{MODE_UPDATE, 32'h7fffffff, 32'h7fffffff, 1'b0, HOME});
    rows.push_back('{MODE_UPDATE, 32'h7fffffff, 32'h7fffffff, 1'b0, HOME});
    rows.push_back('{MODE_CLEAR, 32'sd0, 32'sd0, 1'b1, HOME});
    foreach (rows[i]) send_item(rows[i]);

    for (int ph = 0; ph < 8; ph++) begin
      in_ch.valid <= 1'b0;
      drain();
      case (ph)
        0: begin
          d = 24'hffffff; h = 30'h3fffffff; la = 24'sh7fffff;
        end
        1: begin
          d = '0; h = '0; la = 24'sh800000;
        end
        2: begin
          d = DPT_RESET; h = HPT_RESET; la = 24'sh800000;
        end
        default: begin
          d = 24'($urandom_range(0, 24'h3ffff));
          h = 30'($urandom_range(0, 30'h3fffffff));
          la = 24'($urandom_range(0, 24'hffffff));
          if ($urandom_range(0, 1)) la = la >>> 6;
        end
      endcase
      write_coefs(d, h, la);
      if (ph == 7) idling = 1'b0;
      repeat (200) begin
        sel = $urandom_range(0, 99);
        row.typed = 1'b0;
        row.pose = HOME;
        row.mode = (sel < 4) ? MODE_CLEAR : MODE_UPDATE;
        if (sel < 22) begin
          row.left = $urandom;
          row.right = $urandom;
        end else begin
          span = $urandom_range(0, 22);
          row.left = trk_left + $signed(32'($urandom_range(0, 1 << span)))
                     - $signed(32'(1 << (span > 0 ? span - 1 : 0)));
          row.right = trk_right + $signed(32'($urandom_range(0, 1 << span)))
                      - $signed(32'(1 << (span > 0 ? span - 1 : 0)));
        end
        send_item(row);
      end
    end
    in_ch.valid <= 1'b0;
    while (pending_poses.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0 && pending_poses.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
